/* hw/rtl/ppds_pkg.sv */
// Shared constants and state types for the pairwise proximity danger score unit.
// No dependencies.
package ppds_pkg;

    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 14;

    localparam int CLASS_W = 8;
    localparam int TOL_W   = 12;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_OUT_W = 6;
    localparam int SCORE_W   = 16;
    localparam int SUM_W     = 22;
    localparam int SHADE_W   = 8;
    localparam int TERM_W    = 11;   // holds 0..1024

    localparam logic [SCORE_W-1:0] SCORE_MAX = 16'd64512;
    localparam logic [SUM_W-1:0]   SUM_MAX   = 22'd4128768;
    localparam logic [TERM_W-1:0]  ONE_Q10   = 11'd1024;

    // shade = (SHADE_BASE + min(3*score, SHADE_CAP)) / 20, done as *3277 >> 16
    localparam logic [12:0] SHADE_BASE  = 13'd1034;
    localparam logic [12:0] SHADE_CAP   = 13'd3072;
    localparam logic [11:0] DIV20_RECIP = 12'd3277;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_CLASS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_TOL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHADE_EN     = 2'd2;

    localparam logic [TOL_W-1:0] TOL_RESET = 12'd64;

    typedef enum logic [2:0] {
        S_IDLE, S_CUR, S_CUR_LAT, S_OTH, S_OTH_LAT, S_TERM, S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        T_IDLE, T_MUL, T_CHK, T_SQRT, T_ADJ, T_DIV, T_DONE
    } t_term_state;

endpackage

/* hw/rtl/pairwise_proximity_danger_score_unit.sv */
// Top level of the pairwise proximity danger score unit: box store RAM, frame
// sequencer, score/shade/frame-sum output stage. Depends on ppds_pkg, ppds_ram, ppds_term.
//
// Boxes of the target class are written to the box store one per start pulse
// (busy stays low while loading). The word with frame_end set raises busy and
// scores every kept box in load order; each result word shows on the outputs
// for exactly one cycle with o_valid, o_last_result on the final one, and the
// receiver cannot stall. Scoring walks all ordered pairs through one shared
// term unit: a pair that passes the height and distance checks runs the
// bit-serial square root and the 11-step divide, while a rejected pair skips
// both. Each box also takes its own read, the skip of itself, the end of its
// pair scan and its result. An empty frame gives no result.
module pairwise_proximity_danger_score_unit
    import ppds_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [CLASS_W-1:0]    i_class_code,
    input  logic [COORD_BITS-1:0] i_box_left,
    input  logic [COORD_BITS-1:0] i_box_top,
    input  logic [COORD_BITS-1:0] i_box_width,
    input  logic [COORD_BITS-1:0] i_box_height,
    input  logic                  i_frame_end,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    output logic                  o_valid,
    output logic [IDX_OUT_W-1:0]  o_person_index,
    output logic [SCORE_W-1:0]    o_danger_score,
    output logic                  o_is_danger,
    output logic [SHADE_W-1:0]    o_shade,
    output logic [SUM_W-1:0]      o_frame_sum,
    output logic                  o_last_result
);
    localparam int AW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int BW = 4 * COORD_BITS;

    t_state r_state, n_state;

    logic [CLASS_W-1:0] r_target;
    logic [TOL_W-1:0]   r_tol;
    logic               r_shade_en;

    logic [CW-1:0]      r_cnt, r_i, r_j;
    logic [BW-1:0]      r_cur;
    logic [SCORE_W-1:0] r_score;
    logic [SUM_W-1:0]   r_sum;

    logic [BW-1:0]      rdata;
    logic [AW-1:0]      raddr;
    logic               accept, keep, term_start, term_done;
    logic [CW-1:0]      cnt_inc;
    logic [TERM_W-1:0]  term;
    logic [SCORE_W:0]   score_add;
    logic [SUM_W:0]     sum_add;
    logic [SUM_W-1:0]   sum_sat;
    logic [18:0]        c3;
    logic [12:0]        shade_num;
    logic [24:0]        shade_prod;

    assign accept  = i_start && !o_busy;
    assign keep    = accept && (i_class_code == r_target) && (r_cnt < CW'(MAX_BOXES));
    assign cnt_inc = r_cnt + CW'(keep);
    assign o_busy  = (r_state != S_IDLE);

    ppds_ram #(.WIDTH(BW), .DEPTH(MAX_BOXES)) u_store (
        .i_clk  (i_clk),
        .i_we   (keep),
        .i_waddr(r_cnt[AW-1:0]),
        .i_wdata({i_box_left, i_box_top, i_box_width, i_box_height}),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    ppds_term #(.COORD_BITS(COORD_BITS)) u_term (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(term_start),
        .i_cur  (r_cur),
        .i_oth  (rdata),
        .i_tol  (r_tol),
        .o_done (term_done),
        .o_term (term)
    );

    always_comb begin
        n_state    = r_state;
        raddr      = r_j[AW-1:0];
        term_start = 1'b0;
        case (r_state)
            S_IDLE: if (accept && i_frame_end && cnt_inc != '0) n_state = S_CUR;
            S_CUR: begin
                raddr   = r_i[AW-1:0];
                n_state = S_CUR_LAT;
            end
            S_CUR_LAT: n_state = S_OTH;
            S_OTH: begin
                if (r_j == r_cnt) n_state = S_EMIT;
                else if (r_j != r_i) n_state = S_OTH_LAT;
            end
            S_OTH_LAT: begin
                term_start = 1'b1;
                n_state    = S_TERM;
            end
            S_TERM: if (term_done) n_state = S_OTH;
            S_EMIT: n_state = (r_i + 1'b1 == r_cnt) ? S_IDLE : S_CUR;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        score_add  = (SCORE_W+1)'(r_score) + (SCORE_W+1)'(term);
        sum_add    = (SUM_W+1)'(r_sum) + (SUM_W+1)'(r_score);
        sum_sat    = (sum_add > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum_add[SUM_W-1:0];
        c3         = 19'(r_score) * 19'd3;
        shade_num  = SHADE_BASE + ((c3 > 19'(SHADE_CAP)) ? SHADE_CAP : c3[12:0]);
        shade_prod = 25'(shade_num) * 25'(DIV20_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_target   <= '0;
            r_tol      <= TOL_RESET;
            r_shade_en <= 1'b0;
            r_cnt      <= '0;
            r_sum      <= '0;
            o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == S_EMIT);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TARGET_CLASS: r_target   <= i_cfg_data[CLASS_W-1:0];
                    REG_HEIGHT_TOL:   r_tol      <= i_cfg_data[TOL_W-1:0];
                    REG_SHADE_EN:     r_shade_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt <= (accept && i_frame_end && cnt_inc != '0) ? cnt_inc :
                             (accept && i_frame_end) ? '0 : cnt_inc;
                    r_sum <= '0;
                end
                S_EMIT: begin
                    r_sum <= sum_sat;
                    if (r_i + 1'b1 == r_cnt) r_cnt <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: r_i <= '0;
            S_CUR_LAT: begin
                r_cur   <= rdata;
                r_score <= '0;
                r_j     <= '0;
            end
            S_OTH: if (r_j == r_i && r_j != r_cnt) r_j <= r_j + 1'b1;
            S_TERM: begin
                if (term_done) begin
                    r_j     <= r_j + 1'b1;
                    r_score <= (score_add > (SCORE_W+1)'(SCORE_MAX)) ? SCORE_MAX
                                                                     : score_add[SCORE_W-1:0];
                end
            end
            S_EMIT: begin
                o_person_index <= IDX_OUT_W'(r_i);
                o_danger_score <= r_score;
                o_is_danger    <= (r_score >= SCORE_W'(ONE_Q10));
                o_shade        <= r_shade_en ? shade_prod[23:16] : '0;
                o_frame_sum    <= sum_sat;
                o_last_result  <= (r_i + 1'b1 == r_cnt);
                r_i            <= r_i + 1'b1;
            end
            default: ;
        endcase
    end

    // a result word only follows an emit cycle
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_EMIT))
        else $error("result strobe without emit");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_BOXES))
        else $error("kept count beyond store depth");

    // after the last word of a frame the store is empty and loading resumes
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_result) |-> (r_cnt == '0 && r_state == S_IDLE))
        else $error("frame not closed after last result");

    a_term_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        term_done |-> r_state == S_TERM)
        else $error("term finished outside wait state");
endmodule

/* hw/rtl/ppds_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ppds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/ppds_term.sv */
// Pair term unit: height check, squared distance, bit-serial square root and
// restoring divide giving 1024 - ceil(1024*sqrt(d2)/h). Depends on ppds_pkg.
module ppds_term
    import ppds_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [4*COORD_BITS-1:0] i_cur,
    input  logic [4*COORD_BITS-1:0] i_oth,
    input  logic [TOL_W-1:0]        i_tol,
    output logic                    o_done,
    output logic [TERM_W-1:0]       o_term
);
    localparam int CB  = COORD_BITS;
    localparam int PW  = CB + 1;          // bottom-centre coordinate width
    localparam int D2W = 2 * PW + 1;
    localparam int SW  = CB + 10;         // root width
    localparam int RW  = SW + 3;          // partial remainder width
    localparam int DW  = CB + 11;         // dividend width
    localparam int SCW = $clog2(SW);

    t_term_state r_state, n_state;

    logic [PW-1:0]       r_dx, r_dy;
    logic [CB-1:0]       r_h, r_hdiff;
    logic [TOL_W-1:0]    r_tol;
    logic [D2W-1:0]      r_d2;
    logic [2*CB-1:0]     r_hh;
    logic [CB+7:0]       r_lhs;
    logic [CB+TOL_W-1:0] r_rhs;
    logic [2*SW-1:0]     r_rad;
    logic [RW-1:0]       r_rem;
    logic [SW-1:0]       r_root;
    logic [SCW-1:0]      r_scnt;
    logic [DW-1:0]       r_dvd;
    logic [3:0]          r_k;
    logic [TERM_W-1:0]   r_q;

    logic [CB-1:0] cl, ct, cw, chh, ol, ot, ow, oh;
    logic [PW-1:0] ax, bx, ay, by;
    logic [RW-1:0] rem_sh, trial;
    logic [DW-1:0] hk;

    assign {cl, ct, cw, chh} = i_cur;
    assign {ol, ot, ow, oh}  = i_oth;

    always_comb begin
        ax = PW'(cl) + PW'(cw >> 1);
        bx = PW'(ol) + PW'(ow >> 1);
        ay = PW'(ct) + PW'(chh);
        by = PW'(ot) + PW'(oh);
        rem_sh = {r_rem[RW-3:0], r_rad[2*SW-1 -: 2]};
        trial  = RW'({r_root, 2'b01});
        hk     = DW'(r_h) << r_k;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE: if (i_start) n_state = T_MUL;
            T_MUL:  n_state = T_CHK;
            T_CHK: begin
                if ((CB+TOL_W)'(r_lhs) > r_rhs || r_d2 >= D2W'(r_hh)) begin
                    n_state = T_DONE;
                end else begin
                    n_state = T_SQRT;
                end
            end
            T_SQRT: if (r_scnt == '0) n_state = T_ADJ;
            T_ADJ:  n_state = T_DIV;
            T_DIV:  if (r_k == 4'd0) n_state = T_DONE;
            T_DONE: n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            T_IDLE: begin
                r_dx    <= (ax > bx) ? ax - bx : bx - ax;
                r_dy    <= (ay > by) ? ay - by : by - ay;
                r_h     <= chh;
                r_hdiff <= (chh > oh) ? chh - oh : oh - chh;
                r_tol   <= i_tol;
            end
            T_MUL: begin
                r_d2  <= D2W'(r_dx) * D2W'(r_dx) + D2W'(r_dy) * D2W'(r_dy);
                r_hh  <= r_h * r_h;
                r_lhs <= {r_hdiff, 8'd0};
                r_rhs <= r_h * r_tol;
            end
            T_CHK: begin
                r_q    <= ONE_Q10;   // rejected pair gives zero
                r_rad  <= {r_d2[2*CB-1:0], 20'd0};
                r_rem  <= '0;
                r_root <= '0;
                r_scnt <= SCW'(SW - 1);
            end
            T_SQRT: begin
                r_rad  <= r_rad << 2;
                r_scnt <= r_scnt - 1'b1;
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[SW-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[SW-2:0], 1'b0};
                end
            end
            T_ADJ: begin
                // ceil of the root, then ceil of the divide via +h-1
                r_dvd <= DW'(r_root) + DW'(r_rem != '0) + DW'(r_h) - DW'(1);
                r_k   <= 4'd10;
                r_q   <= '0;
            end
            T_DIV: begin
                r_k <= r_k - 1'b1;
                if (r_dvd >= hk) begin
                    r_dvd    <= r_dvd - hk;
                    r_q[r_k] <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_done = (r_state == T_DONE);
    assign o_term = (r_q >= ONE_Q10) ? '0 : ONE_Q10 - r_q;
endmodule
